// File: sv/ictf_pkg.sv
// ----------------------------------------------------------------------------
// ictf_pkg
// Types, register indexes and the atan table shared by the tilt filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ictf_pkg;

	localparam int ZFRAC       = 20;
	localparam int GYRO_COUNTS = 131;
	localparam int WEIGHT_ONE  = 1024;
	localparam int ACC_SHIFT   = 12;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACCEL_X_OFFSET  = 3'd0,
		REG_ACCEL_Y_OFFSET  = 3'd1,
		REG_ACCEL_Z_OFFSET  = 3'd2,
		REG_GYRO_X_OFFSET   = 3'd3,
		REG_GYRO_Y_OFFSET   = 3'd4,
		REG_GYRO_WEIGHT     = 3'd5,
		REG_COUNTING_ENABLE = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic               command;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
	} item_t;

	typedef struct packed {
		logic signed [23:0] roll_angle;
		logic signed [23:0] pitch_angle;
	} result_t;

	typedef struct packed {
		logic signed [15:0] accel_x_offset;
		logic signed [15:0] accel_y_offset;
		logic signed [15:0] accel_z_offset;
		logic signed [15:0] gyro_x_offset;
		logic signed [15:0] gyro_y_offset;
		logic [10:0]        gyro_weight;
		logic               counting_enable;
	} cfg_t;

	// corrected sample waiting for the back end
	typedef struct packed {
		logic signed [16:0] ax;
		logic signed [16:0] ay;
		logic signed [16:0] az;
		logic signed [16:0] gx;
		logic signed [16:0] gy;
		logic [15:0]        ticks;
	} smp_t;

	typedef struct packed {
		logic take;
		logic load;
	} bst_t;

	// atan(2^-i) in degrees, 20 fraction bits
	function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
		logic signed [31:0] r;
		case (i)
			5'd0:  r = 32'sd47185920;
			5'd1:  r = 32'sd27855475;
			5'd2:  r = 32'sd14718068;
			5'd3:  r = 32'sd7471121;
			5'd4:  r = 32'sd3750058;
			5'd5:  r = 32'sd1876857;
			5'd6:  r = 32'sd938658;
			5'd7:  r = 32'sd469357;
			5'd8:  r = 32'sd234682;
			5'd9:  r = 32'sd117342;
			5'd10: r = 32'sd58671;
			5'd11: r = 32'sd29335;
			5'd12: r = 32'sd14668;
			5'd13: r = 32'sd7334;
			5'd14: r = 32'sd3667;
			5'd15: r = 32'sd1833;
			5'd16: r = 32'sd917;
			5'd17: r = 32'sd458;
			5'd18: r = 32'sd229;
			5'd19: r = 32'sd115;
			5'd20: r = 32'sd57;
			5'd21: r = 32'sd29;
			5'd22: r = 32'sd14;
			5'd23: r = 32'sd7;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage

// File: sv/ictf_front.sv
// ----------------------------------------------------------------------------
// ictf_front
// Takes requests, counts ticks, corrects samples and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ictf_front import ictf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  push,
	input  item_t item,
	output logic  full,
	output logic  smp_valid,
	output smp_t  smp,
	input  logic  take
);

	localparam int QDEPTH = 2;

	logic [15:0] tick_q;
	logic [1:0]  cnt_q;
	logic        wp_q, rp_q;
	smp_t        mem_q [QDEPTH];
	logic        acc_ok, is_smp;
	smp_t        wr;

	assign full      = (cnt_q == 2'(QDEPTH));
	assign smp_valid = (cnt_q != 2'd0);
	assign smp       = mem_q[rp_q];
	assign acc_ok    = push && !full;
	assign is_smp    = acc_ok && item.command;

	always_comb begin
		wr.ax    = 17'(item.accel_x) - 17'(cfg.accel_x_offset);
		wr.ay    = 17'(item.accel_y) - 17'(cfg.accel_y_offset);
		wr.az    = 17'(item.accel_z) - 17'(cfg.accel_z_offset);
		wr.gx    = 17'(item.gyro_x) - 17'(cfg.gyro_x_offset);
		wr.gy    = 17'(item.gyro_y) - 17'(cfg.gyro_y_offset);
		wr.ticks = tick_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			cnt_q  <= '0;
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
		end else begin
			if (is_smp) begin
				tick_q <= '0;
			end else if (acc_ok && cfg.counting_enable && tick_q != 16'hFFFF) begin
				tick_q <= tick_q + 16'd1;
			end
			if (is_smp) wp_q <= ~wp_q;
			if (take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(is_smp) - 2'(take);
		end
	end

	always_ff @(posedge clk) begin
		if (is_smp) mem_q[wp_q] <= wr;
	end

endmodule

// File: sv/ictf_back.sv
// ----------------------------------------------------------------------------
// ictf_back
// Sequencer: root, shared cordic, gyro divide, blend and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ictf_back import ictf_pkg::*; #(
	parameter int TICKS_PER_SECOND = 1000,
	parameter int ANGLE_FRAC_BITS  = 8,
	parameter int CORDIC_STEPS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [10:0] weight,
	input  logic        smp_valid,
	input  smp_t        smp,
	output bst_t        st,
	input  logic        pop,
	output logic        empty,
	output result_t     result
);

	localparam int CW     = 34;
	localparam int ZW     = 32;
	localparam int RT_W   = 58;
	localparam int ROOT_W = 29;
	localparam int SH     = ZFRAC - ANGLE_FRAC_BITS;
	localparam int NUM_W  = 34 + ANGLE_FRAC_BITS;
	localparam int DVD_W  = NUM_W + 1;
	localparam int DEN    = GYRO_COUNTS * TICKS_PER_SECOND;
	localparam int HALF   = DEN / 2;
	localparam int DEN_W  = $clog2(DEN + 1);
	localparam int QW     = DVD_W - DEN_W + 1;
	localparam int RW     = DEN_W + 4;
	localparam int XT_SH  = DVD_W - 32;
	localparam int RSH    = DEN_W + 63 - DVD_W;
	localparam int SUM_W  = DVD_W + 2;
	localparam int BL_W   = 37;
	localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180 * 2**ZFRAC);
	localparam logic signed [ZW-1:0] ZRND      = ZW'(2**(SH - 1));
	localparam logic [DEN_W-1:0]     DEN_V     = DEN_W'(DEN);
	// floor(2^(DEN_W+31) / DEN), always below 2^32
	localparam logic [31:0]          RECIP     = 32'((64'd1 << (DEN_W + 31)) / 64'(DEN));

	typedef enum logic [15:0] {
		S_IDLE  = 16'b0000000000000001,
		S_SQ1   = 16'b0000000000000010,
		S_SQ2   = 16'b0000000000000100,
		S_ROOT  = 16'b0000000000001000,
		S_CINIT = 16'b0000000000010000,
		S_CROT  = 16'b0000000000100000,
		S_CDONE = 16'b0000000001000000,
		S_GMUL  = 16'b0000000010000000,
		S_GREC  = 16'b0000000100000000,
		S_GREM  = 16'b0000001000000000,
		S_GDIV  = 16'b0000010000000000,
		S_GSUM  = 16'b0000100000000000,
		S_BL1   = 16'b0001000000000000,
		S_BL2   = 16'b0010000000000000,
		S_BL3   = 16'b0100000000000000,
		S_OUT   = 16'b1000000000000000
	} state_t;

	state_t state_q, state_d;

	logic                     ph_q;
	logic signed [16:0]       ax_q, ay_q, az_q, gx_q, gy_q;
	logic [15:0]              ticks_q;
	logic [33:0]              sq_q;
	logic [RT_W-1:0]          rv_q, rr_q, rb_q;
	logic signed [CW-1:0]     cx_q, cy_q;
	logic signed [ZW-1:0]     cz_q;
	logic                     czero_q;
	logic [4:0]               cnt_q;
	logic signed [23:0]       roll_acc_q, pitch_acc_q;
	logic                     neg_q;
	logic [DVD_W-1:0]         dvd_q;
	logic [QW-1:0]            quo_q;
	logic [RW-1:0]            rem_q;
	logic signed [23:0]       g_q;
	logic signed [BL_W-1:0]   bl_q;
	logic signed [23:0]       roll_est_q, pitch_est_q;
	result_t                  res_q;
	logic                     res_valid_q;

	logic                     take, load;
	logic [RT_W:0]            r_try;
	logic signed [CW-1:0]     ix, iy, xs, ys;
	logic signed [ZW-1:0]     zr;
	logic signed [23:0]       ang;
	logic signed [16:0]       rate;
	logic signed [33:0]       gprod;
	logic signed [NUM_W-1:0]  numv;
	logic [NUM_W-1:0]         magv;
	logic [63:0]              rprod;
	logic [DVD_W:0]           qden, remv;
	logic                     ge;
	logic signed [SUM_W-1:0]  inc, sumv;
	logic signed [23:0]       est_sel, acc_sel;
	logic [11:0]              wc;
	logic signed [BL_W-1:0]   blr;

	function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
		logic signed [23:0] r;
		if (v > 64'sd8388607) r = 24'sh7FFFFF;
		else if (v < -64'sd8388608) r = 24'sh800000;
		else r = v[23:0];
		return r;
	endfunction

	assign take    = (state_q == S_IDLE) && smp_valid;
	assign load    = (state_q == S_OUT) && (!res_valid_q || pop);
	assign st.take = take;
	assign st.load = load;
	assign empty   = !res_valid_q;
	assign result  = res_q;

	always_comb begin
		r_try   = {1'b0, rr_q} + {1'b0, rb_q};
		if (!ph_q) begin
			iy = CW'(ay_q) <<< ACC_SHIFT;
			ix = CW'(az_q) <<< ACC_SHIFT;
		end else begin
			iy = -(CW'(ax_q) <<< ACC_SHIFT);
			ix = signed'(CW'(rr_q[ROOT_W-1:0]));
		end
		xs      = cx_q >>> cnt_q;
		ys      = cy_q >>> cnt_q;
		zr      = cz_q + ZRND;
		ang     = czero_q ? 24'sd0 : 24'(zr >>> SH);
		rate    = ph_q ? gy_q : gx_q;
		gprod   = 34'(rate) * 34'(signed'({1'b0, ticks_q}));
		numv    = NUM_W'(gprod) <<< ANGLE_FRAC_BITS;
		magv    = numv[NUM_W-1] ? NUM_W'(-numv) : NUM_W'(numv);
		// quotient estimate from the top 32 dividend bits, never above the true one
		rprod   = 64'(dvd_q[DVD_W-1:XT_SH]) * 64'(RECIP);
		qden    = (DVD_W + 1)'(quo_q) * (DVD_W + 1)'(DEN_V);
		remv    = {1'b0, dvd_q} - qden;
		ge      = (rem_q >= RW'(DEN));
		inc     = neg_q ? -signed'(SUM_W'(quo_q)) : signed'(SUM_W'(quo_q));
		est_sel = ph_q ? pitch_est_q : roll_est_q;
		acc_sel = ph_q ? pitch_acc_q : roll_acc_q;
		sumv    = SUM_W'(est_sel) + inc;
		wc      = 12'(WEIGHT_ONE) - {1'b0, weight};
		blr     = (bl_q + BL_W'(WEIGHT_ONE / 2)) >>> 10;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (smp_valid) state_d = S_SQ1;
			S_SQ1:   state_d = S_SQ2;
			S_SQ2:   state_d = S_ROOT;
			S_ROOT:  if (rb_q[0]) state_d = S_CINIT;
			S_CINIT: state_d = S_CROT;
			S_CROT:  if (cnt_q == 5'(CORDIC_STEPS - 1)) state_d = S_CDONE;
			S_CDONE: state_d = ph_q ? S_GMUL : S_CINIT;
			S_GMUL:  state_d = S_GREC;
			S_GREC:  state_d = S_GREM;
			S_GREM:  state_d = S_GDIV;
			S_GDIV:  if (!ge) state_d = S_GSUM;
			S_GSUM:  state_d = S_BL1;
			S_BL1:   state_d = S_BL2;
			S_BL2:   state_d = S_BL3;
			S_BL3:   state_d = ph_q ? S_OUT : S_GMUL;
			S_OUT:   if (load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= 1'b0;
			res_valid_q <= 1'b0;
			roll_est_q  <= '0;
			pitch_est_q <= '0;
		end else begin
			state_q <= state_d;
			// phase flips after each cordic run and each blend
			if (state_q == S_CDONE || state_q == S_BL3) ph_q <= ~ph_q;
			if (state_q == S_BL3) begin
				if (ph_q) pitch_est_q <= sat24(64'(blr));
				else roll_est_q <= sat24(64'(blr));
			end
			if (load) res_valid_q <= 1'b1;
			else if (pop) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ax_q    <= smp.ax;
				ay_q    <= smp.ay;
				az_q    <= smp.az;
				gx_q    <= smp.gx;
				gy_q    <= smp.gy;
				ticks_q <= smp.ticks;
			end
			S_SQ1: sq_q <= 34'(ay_q * ay_q);
			S_SQ2: begin
				rv_q <= {sq_q + 34'(az_q * az_q), 24'd0};
				rr_q <= '0;
				rb_q <= RT_W'(1) << (RT_W - 2);
			end
			S_ROOT: begin
				if ({1'b0, rv_q} >= r_try) begin
					rv_q <= rv_q - r_try[RT_W-1:0];
					rr_q <= (rr_q >> 1) + rb_q;
				end else begin
					rr_q <= rr_q >> 1;
				end
				rb_q <= rb_q >> 2;
			end
			S_CINIT: begin
				cnt_q   <= '0;
				czero_q <= (ix == '0) && (iy == '0);
				if (ix < 0) begin
					cz_q <= (iy >= 0) ? HALF_TURN : -HALF_TURN;
					cx_q <= -ix;
					cy_q <= -iy;
				end else begin
					cz_q <= '0;
					cx_q <= ix;
					cy_q <= iy;
				end
			end
			S_CROT: begin
				cnt_q <= cnt_q + 5'd1;
				if (!cy_q[CW-1]) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + atan_deg(cnt_q);
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - atan_deg(cnt_q);
				end
			end
			S_CDONE: begin
				if (ph_q) pitch_acc_q <= ang;
				else roll_acc_q <= ang;
			end
			S_GMUL: begin
				neg_q <= numv[NUM_W-1];
				dvd_q <= DVD_W'(magv) + DVD_W'(HALF);
			end
			S_GREC: quo_q <= rprod[63:RSH];
			S_GREM: rem_q <= remv[RW-1:0];
			// the estimate is at most a few short, step it up while rem >= den
			S_GDIV: begin
				if (ge) begin
					rem_q <= rem_q - RW'(DEN);
					quo_q <= quo_q + QW'(1);
				end
			end
			S_GSUM: g_q  <= sat24(64'(sumv));
			S_BL1:  bl_q <= BL_W'(signed'({1'b0, weight})) * BL_W'(g_q);
			S_BL2:  bl_q <= bl_q + BL_W'(signed'({1'b0, wc})) * BL_W'(acc_sel);
			S_OUT: begin
				if (load) begin
					res_q.roll_angle  <= roll_est_q;
					res_q.pitch_angle <= pitch_est_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: sv/imu_complementary_tilt_filter_top.sv
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter_top
// A tick request only advances the tick count; a sample request queues in two entries.
// Each sample runs through the squares, the root and two cordic runs, then per
// axis a gyro divide with a quotient fix step when needed and a blend.
// One sample is in the back end at a time; the next is taken once the result is loaded.
// arst_n clears the tick count, estimates, queue and registers to defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imu_complementary_tilt_filter_top import ictf_pkg::*; #(
	parameter int TICKS_PER_SECOND = 1000,
	parameter int ANGLE_FRAC_BITS  = 8,
	parameter int CORDIC_STEPS     = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	output logic                  full,
	input  item_t                 item,
	output logic                  empty,
	input  logic                  pop,
	output result_t               result
);

	cfg_t        cfg_q;
	logic [10:0] weight;
	logic        smp_valid;
	smp_t        smp;
	bst_t        st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_x_offset  <= -16'sd11007;
			cfg_q.accel_y_offset  <= 16'sd10018;
			cfg_q.accel_z_offset  <= -16'sd32746;
			cfg_q.gyro_x_offset   <= 16'sd433;
			cfg_q.gyro_y_offset   <= 16'sd357;
			cfg_q.gyro_weight     <= 11'd1004;
			cfg_q.counting_enable <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ACCEL_X_OFFSET:  cfg_q.accel_x_offset  <= cfg_data;
				REG_ACCEL_Y_OFFSET:  cfg_q.accel_y_offset  <= cfg_data;
				REG_ACCEL_Z_OFFSET:  cfg_q.accel_z_offset  <= cfg_data;
				REG_GYRO_X_OFFSET:   cfg_q.gyro_x_offset   <= cfg_data;
				REG_GYRO_Y_OFFSET:   cfg_q.gyro_y_offset   <= cfg_data;
				REG_GYRO_WEIGHT:     cfg_q.gyro_weight     <= cfg_data[10:0];
				REG_COUNTING_ENABLE: cfg_q.counting_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// weights above one count as one
	assign weight = (cfg_q.gyro_weight > 11'(WEIGHT_ONE)) ? 11'(WEIGHT_ONE)
	                                                      : cfg_q.gyro_weight;

	ictf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.item      (item),
		.full      (full),
		.smp_valid (smp_valid),
		.smp       (smp),
		.take      (st.take)
	);

	ictf_back #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND),
		.ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
		.CORDIC_STEPS     (CORDIC_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.weight    (weight),
		.smp_valid (smp_valid),
		.smp       (smp),
		.st        (st),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

`ifndef NO_ASSERTIONS
	// back end never pulls from an empty queue
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		st.take |-> smp_valid) else $error("take from empty sample queue");

	// a new result never overwrites one not yet taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		st.load |-> (empty || pop)) else $error("result overwritten");

	// a loaded result shows up on the next edge
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		st.load |=> !empty) else $error("loaded result not visible");
`endif

endmodule
